@@ hw/rtl/smt_pkg.sv @@
package smt_pkg;

  // Default geometry of the timeline store
  localparam int SMT_DEPTH     = 16;
  localparam int SMT_TIME_BITS = 32;

  // Request codes
  localparam logic [1:0] REQ_ADD_ABS = 2'd0;
  localparam logic [1:0] REQ_ADD_REL = 2'd1;
  localparam logic [1:0] REQ_ADVANCE = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FINISHED  = 2'd1;
  localparam logic [1:0] ST_ZERO_DELTA = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] time_value;
  } req_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] current_time;
  } res_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_ADV_CMP,
    S_DONE
  } smt_state_t;

endpackage

@@ hw/rtl/smt_store.sv @@
module smt_store import smt_pkg::*; #(
  parameter int DEPTH     = SMT_DEPTH,
  parameter int TIME_BITS = SMT_TIME_BITS,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [TIME_BITS-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic [TIME_BITS-1:0] rdata
);

  logic [TIME_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/smt_ctrl.sv @@
module smt_ctrl import smt_pkg::*; #(
  parameter int DEPTH     = SMT_DEPTH,
  parameter int TIME_BITS = SMT_TIME_BITS,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW       = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  req_item_t            req,
  output logic                 res_valid,
  input  logic                 res_ready,
  output res_item_t            res,
  output logic                 mem_we,
  output logic [AW-1:0]        mem_waddr,
  output logic [TIME_BITS-1:0] mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  input  logic [TIME_BITS-1:0] mem_rdata
);

  localparam int WIDE = (TIME_BITS > 32) ? TIME_BITS : 32;

  smt_state_t           state, state_next;
  logic [AW-1:0]        head, head_next;
  logic [AW-1:0]        tail, tail_next;
  logic [CW-1:0]        count, count_next;
  logic [TIME_BITS-1:0] now, now_next;
  logic [AW-1:0]        hole, hole_next;
  logic [AW-1:0]        rd, rd_next;
  logic [CW-1:0]        left, left_next;
  logic [TIME_BITS-1:0] ins_val, ins_val_next;
  logic [1:0]           pend_status, pend_status_next;
  logic                 res_valid_next;
  res_item_t            res_next;

  logic                 accept;
  logic                 fin;
  logic [1:0]           fin_status;
  logic                 slot_free;
  logic [WIDE-1:0]      val_w;
  logic [WIDE-1:0]      tmax_w;
  logic [WIDE-1:0]      sat_w;
  logic [WIDE-1:0]      now_w;
  logic [TIME_BITS-1:0] abs_t;
  logic [TIME_BITS:0]   rel_sum;
  logic [TIME_BITS-1:0] rel_t;
  logic                 full;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
  endfunction

  // Clamp the incoming time and form the saturated relative target
  always_comb begin
    val_w   = WIDE'(req.time_value);
    tmax_w  = WIDE'({TIME_BITS{1'b1}});
    sat_w   = (val_w > tmax_w) ? tmax_w : val_w;
    abs_t   = sat_w[TIME_BITS-1:0];
    rel_sum = {1'b0, now} + {1'b0, abs_t};
    rel_t   = rel_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : rel_sum[TIME_BITS-1:0];
  end

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign full      = (count == CW'(DEPTH));
  assign slot_free = !res_valid || res_ready;

  // Sequence inserts and pops through the store
  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    now_next         = now;
    hole_next        = hole;
    rd_next          = rd;
    left_next        = left;
    ins_val_next     = ins_val;
    pend_status_next = pend_status;
    mem_we           = 1'b0;
    mem_waddr        = hole;
    mem_wdata        = ins_val;
    mem_raddr        = head;
    fin              = 1'b0;
    fin_status       = ST_OK;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_ADD_ABS, REQ_ADD_REL: begin
              if (req.req_type == REQ_ADD_REL && req.time_value == 32'd0) begin
                fin        = 1'b1;
                fin_status = ST_ZERO_DELTA;
              end else if (full) begin
                fin        = 1'b1;
                fin_status = ST_FULL;
              end else begin
                ins_val_next = (req.req_type == REQ_ADD_REL) ? rel_t : abs_t;
                if (count == '0) begin
                  // Empty store: place the time straight at the tail
                  mem_we     = 1'b1;
                  mem_waddr  = tail;
                  mem_wdata  = ins_val_next;
                  count_next = count + CW'(1);
                  tail_next  = ptr_inc(tail);
                  fin        = 1'b1;
                  fin_status = ST_OK;
                end else begin
                  mem_raddr  = ptr_dec(tail);
                  rd_next    = ptr_dec(tail);
                  hole_next  = tail;
                  left_next  = count - CW'(1);
                  state_next = S_INS_CMP;
                end
              end
            end
            REQ_ADVANCE: begin
              if (count == '0) begin
                fin        = 1'b1;
                fin_status = ST_FINISHED;
              end else begin
                mem_raddr  = head;
                state_next = S_ADV_CMP;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = ST_OK;
            end
          endcase
        end
      end

      S_INS_CMP: begin
        if (mem_rdata > ins_val) begin
          // Shift the larger entry up into the hole and move the hole down
          mem_we    = 1'b1;
          mem_waddr = hole;
          mem_wdata = mem_rdata;
          hole_next = rd;
          if (left != '0) begin
            mem_raddr = ptr_dec(rd);
            rd_next   = ptr_dec(rd);
            left_next = left - CW'(1);
          end else begin
            state_next = S_INS_PUT;
          end
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = hole;
          mem_wdata  = ins_val;
          count_next = count + CW'(1);
          tail_next  = ptr_inc(tail);
          fin        = 1'b1;
          fin_status = ST_OK;
        end
      end

      S_INS_PUT: begin
        mem_we     = 1'b1;
        mem_waddr  = hole;
        mem_wdata  = ins_val;
        count_next = count + CW'(1);
        tail_next  = ptr_inc(tail);
        fin        = 1'b1;
        fin_status = ST_OK;
      end

      S_ADV_CMP: begin
        // Pop the head; drop entries equal to the current time
        head_next  = ptr_inc(head);
        count_next = count - CW'(1);
        if (mem_rdata == now) begin
          if (count == CW'(1)) begin
            fin        = 1'b1;
            fin_status = ST_FINISHED;
          end else begin
            mem_raddr = ptr_inc(head);
          end
        end else begin
          now_next   = mem_rdata;
          fin        = 1'b1;
          fin_status = ST_OK;
        end
      end

      S_DONE: begin
        fin        = 1'b1;
        fin_status = pend_status;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Hand the result to the output register, or hold it until there is room
    res_valid_next = res_valid && !res_ready;
    res_next       = res;
    now_w          = WIDE'(now_next);
    if (fin) begin
      if (slot_free) begin
        res_valid_next        = 1'b1;
        res_next.status       = fin_status;
        res_next.current_time = now_w[31:0];
        state_next            = S_IDLE;
      end else begin
        pend_status_next = fin_status;
        state_next       = S_DONE;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      now       <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      now       <= now_next;
      res_valid <= res_valid_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    hole        <= hole_next;
    rd          <= rd_next;
    left        <= left_next;
    ins_val     <= ins_val_next;
    pend_status <= pend_status_next;
    res         <= res_next;
  end

endmodule

@@ hw/rtl/sorted_milestone_timeline.sv @@
// Channel | Handshake           | Payload
// req     | req_valid/req_ready | req_item_t: req_type, time_value
// res     | res_valid/res_ready | res_item_t: status, current_time
//
// One item at a time, one result per item, all through a store with one write and one read port.
// Add: later entries shift up and the new time fills the hole; if empty, the tail.
// Advance: pops entries at the current time, then pops the next as the new time.
// Status-only replies (zero delta, full, empty, unknown) are decided in the idle state.
// Reset is synchronous; the store needs no clearing. A stalled result is held.
module sorted_milestone_timeline import smt_pkg::*; #(
  parameter int DEPTH     = SMT_DEPTH,
  parameter int TIME_BITS = SMT_TIME_BITS,
  localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      res_valid,
  input  logic      res_ready,
  output res_item_t res
);

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [TIME_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [TIME_BITS-1:0] mem_rdata;

  // Sequencer: pointers, current time and result register
  smt_ctrl #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Circular milestone store, kept sorted from head to tail
  smt_store #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

@@ tb/smt_timeline_monitor.sv @@
`timescale 1ns / 1ps

module smt_timeline_monitor import smt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_ready,
  input  req_item_t req,
  input  logic      res_valid,
  input  logic      res_ready,
  input  res_item_t res,
  output int        fail_count,
  output int        outstanding
);

  // Shadow timeline: sorted milestones, their count and the current time
  logic [SMT_TIME_BITS-1:0] milestones [SMT_DEPTH];
  int                       milestone_count;
  logic [SMT_TIME_BITS-1:0] timeline_now;

  res_item_t                pending_results [$];
  res_item_t                oldest;
  int                       mismatches = 0;
  int                       waiting    = 0;

  assign fail_count  = mismatches;
  assign outstanding = waiting;

  // Print one line for each mismatch and count it
  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Remove the earliest milestone and close the gap
  function automatic void drop_head();
    int i;
    for (i = 1; i < milestone_count; i++) begin
      milestones[i-1] = milestones[i];
    end
    milestone_count--;
  endfunction

  // Insert after any equal entries so duplicates keep arrival order
  function automatic logic [1:0] insert_milestone(logic [SMT_TIME_BITS-1:0] t);
    int pos;
    int i;
    if (milestone_count >= SMT_DEPTH) begin
      return ST_FULL;
    end
    pos = 0;
    while (pos < milestone_count && milestones[pos] <= t) begin
      pos++;
    end
    for (i = milestone_count; i > pos; i--) begin
      milestones[i] = milestones[i-1];
    end
    milestones[pos] = t;
    milestone_count++;
    return ST_OK;
  endfunction

  // Work out the status and time that one item leaves behind
  function automatic res_item_t predict_timeline(req_item_t it);
    res_item_t                r;
    logic [SMT_TIME_BITS:0]   sum;
    r.status = ST_OK;
    case (it.req_type)
      REQ_ADD_ABS: begin
        r.status = insert_milestone(it.time_value);
      end
      REQ_ADD_REL: begin
        if (it.time_value == '0) begin
          r.status = ST_ZERO_DELTA;
        end else begin
          // saturate the relative time at the largest tick
          sum = {1'b0, timeline_now} + {1'b0, it.time_value};
          if (sum[SMT_TIME_BITS]) begin
            sum = {1'b0, {SMT_TIME_BITS{1'b1}}};
          end
          r.status = insert_milestone(sum[SMT_TIME_BITS-1:0]);
        end
      end
      REQ_ADVANCE: begin
        // drop milestones already reached, then step to the next one
        while (milestone_count > 0 && milestones[0] == timeline_now) begin
          drop_head();
        end
        if (milestone_count == 0) begin
          r.status = ST_FINISHED;
        end else begin
          timeline_now = milestones[0];
          drop_head();
        end
      end
      default: begin
      end
    endcase
    r.current_time = timeline_now;
    return r;
  endfunction

  // Predict on each accepted item, compare on each accepted result
  always @(posedge clk) begin
    if (rst) begin
      milestone_count = 0;
      timeline_now    = '0;
      pending_results.delete();
    end else begin
      if (req_valid && req_ready) begin
        pending_results.push_back(predict_timeline(req));
      end
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d time %0d",
                                    res.status, res.current_time));
        end else begin
          oldest = pending_results.pop_front();
          if (res.status !== oldest.status) begin
            report_mismatch($sformatf("status %0d, expected %0d",
                                      res.status, oldest.status));
          end
          if (res.current_time !== oldest.current_time) begin
            report_mismatch($sformatf("current_time %0d, expected %0d",
                                      res.current_time, oldest.current_time));
          end
        end
      end
    end
    waiting = pending_results.size();
  end

endmodule

@@ tb/tb_sorted_milestone_timeline.sv @@
`timescale 1ns / 1ps

module tb_sorted_milestone_timeline;
  import smt_pkg::*;

  // Request code the block must answer without acting on it
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int         BLOCKS     = 36;
  localparam int         BLOCK_LEN  = 40;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req       = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  res_item_t res;

  int        fail_count;
  int        outstanding;

  // Idling switches and a one-off long receiver hold-off
  bit        tx_idle   = 1'b1;
  bit        rx_idle   = 1'b1;
  int        long_hold = 0;

  sorted_milestone_timeline i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  smt_timeline_monitor i_monitor (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Offer one item, after a random gap when idling is on, and hold it until accepted
  task automatic send_item(logic [1:0] kind, logic [31:0] value);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid       = 1'b1;
    req.req_type    = kind;
    req.time_value  = value;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // Mostly a small time window so equal times and backward steps are common
  function automatic logic [31:0] pick_abs();
    case ($urandom_range(0, 15))
      0:       return $urandom();
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 4);
      default: return $urandom_range(0, 48);
    endcase
  endfunction

  function automatic logic [31:0] pick_delta();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return $urandom();
      2:       return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 8);
    endcase
  endfunction

  // Receiver: random stall per result when idling is on, plus the long hold-off when asked
  initial begin
    int stall;
    while (rst) @(negedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 11) : 0;
      if (long_hold != 0) begin
        stall     = long_hold;
        long_hold = 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        res_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ready = 1'b1;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    int add_pct;
    int roll;
    int blk;
    int n;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Empty timeline, zero delta, unused code
    send_item(REQ_ADVANCE, 32'h0);
    send_item(REQ_ADD_REL, 32'h0);
    send_item(REQ_UNUSED,  32'hFFFF_FFFF);
    // Milestone at the current time is skipped on advance
    send_item(REQ_ADD_ABS, 32'd0);
    send_item(REQ_ADD_ABS, 32'd100);
    send_item(REQ_ADVANCE, 32'hFFFF_FFFF);
    // Relative add that saturates, then a milestone in the past
    send_item(REQ_ADD_REL, 32'hFFFF_FFFF);
    send_item(REQ_ADD_ABS, 32'd50);
    send_item(REQ_ADVANCE, 32'h0);
    send_item(REQ_ADVANCE, 32'h0);
    // Store now empty: drains to finished, time holds
    send_item(REQ_ADVANCE, 32'h0);
    // Fill the store with duplicates and extremes, then overflow it
    send_item(REQ_ADD_ABS, 32'h0000_0000);
    send_item(REQ_ADD_ABS, 32'h0000_0000);
    send_item(REQ_ADD_ABS, 32'hFFFF_FFFF);
    send_item(REQ_ADD_ABS, 32'hAAAA_AAAA);
    send_item(REQ_ADD_ABS, 32'h5555_5555);
    for (n = 5; n < SMT_DEPTH; n++) begin
      send_item(REQ_ADD_ABS, pick_abs());
    end
    send_item(REQ_ADD_ABS, 32'd7);
    send_item(REQ_ADD_REL, 32'h0);
    send_item(REQ_ADD_REL, 32'd5);

    // Random blocks, each with its own add/advance balance and idling
    for (blk = 0; blk < BLOCKS; blk++) begin
      case ($urandom_range(0, 2))
        0:       add_pct = 30;
        1:       add_pct = 55;
        default: add_pct = 80;
      endcase
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (blk == 9) begin
        // stall the output long enough for the input to back up
        tx_idle   = 1'b0;
        long_hold = 300;
      end
      for (n = 0; n < BLOCK_LEN; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < add_pct) begin
          if ($urandom_range(0, 1) != 0) begin
            send_item(REQ_ADD_ABS, pick_abs());
          end else begin
            send_item(REQ_ADD_REL, pick_delta());
          end
        end else if (roll < 98) begin
          send_item(REQ_ADVANCE, $urandom());
        end else begin
          send_item(REQ_UNUSED, $urandom());
        end
      end
    end

    @(negedge clk);
    req_valid = 1'b0;

    // Drain the remaining results, then allow the block to settle
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
